>>> hdl/qtu_pkg.sv
// Shared types and constants of the Q-table update and greedy select block.
`timescale 1ns / 1ps
`default_nettype none

package qtu_pkg;

    localparam int Q_W             = 32;
    localparam int ACTIONS         = 4;
    localparam int STATE_W         = 16;
    localparam int ACT_W           = 2;
    localparam int STATE_COUNT_DEF = 65536;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES_IN_USE = 2'd2;

    localparam logic [15:0] LEARNING_RATE_RST = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST      = 16'd62259;
    localparam logic [16:0] STATES_IN_USE_RST = 17'd51200;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    typedef logic signed [Q_W-1:0] qval_t;
    typedef logic [ACTIONS-1:0][Q_W-1:0] qrow_t;

    typedef struct packed {
        logic                      cmd;
        logic [STATE_W-1:0]        current_state;
        logic [ACT_W-1:0]          action;
        logic [STATE_W-1:0]        next_state;
        logic signed [Q_W-1:0]     reward;
        logic [ACTIONS-1:0]        allowed_mask;
    } req_t;

    typedef struct packed {
        logic [ACT_W-1:0]          chosen_action;
        logic signed [Q_W-1:0]     q_value;
        logic                      valid_res;
    } rsp_t;

endpackage

`default_nettype wire

>>> hdl/qtu_best.sv
// Best allowed action of one table row, lowest index on a tie.
`timescale 1ns / 1ps
`default_nettype none

module qtu_best
    import qtu_pkg::*;
(
    input  qrow_t              row,
    input  logic [ACTIONS-1:0] mask,
    output logic [ACT_W-1:0]   idx,
    output qval_t              value
);

    qval_t v0;
    qval_t v1;
    qval_t v2;
    qval_t v3;
    qval_t val_lo;
    qval_t val_hi;
    logic  pick_lo;
    logic  pick_hi;
    logic  have_lo;
    logic  have_hi;
    logic  pick_top;

    assign v0 = row[0];
    assign v1 = row[1];
    assign v2 = row[2];
    assign v3 = row[3];

    assign pick_lo = mask[1] && (!mask[0] || (v1 > v0));
    assign pick_hi = mask[3] && (!mask[2] || (v3 > v2));
    assign have_lo = mask[0] || mask[1];
    assign have_hi = mask[2] || mask[3];
    assign val_lo  = pick_lo ? v1 : v0;
    assign val_hi  = pick_hi ? v3 : v2;

    assign pick_top = have_hi && (!have_lo || (val_hi > val_lo));

    assign idx   = pick_top ? {1'b1, pick_hi} : {1'b0, pick_lo};
    assign value = pick_top ? val_hi : val_lo;

endmodule

`default_nettype wire

>>> hdl/q_table_update_and_greedy_select.sv
// Top level: Q-value table memory, update sequencer and greedy select.
//
//  channel  signals                          carries
//  -------  -------------------------------  -------------------------------
//  req      req_valid / req_ready / req      one update or select request
//  rsp      rsp_valid / rsp_ready / rsp      one result per request
//  cfg      cfg_valid / cfg_ready / cfg_*    register index and write data
//
// An update steps through S_MAX, S_MUL1, S_MUL2, S_MUL3 and S_WR, set by the single table
// port and the multiply chain: two row reads, three multiply steps, write-back.
// A select or a rejected request steps through S_SEL or S_REJ alone.
// After reset a clearing pass writes zero to STATE_COUNT rows, one row a
// cycle, with req_ready low; cfg writes are taken throughout.
// A result waiting on rsp_ready holds the block in its final step.
`timescale 1ns / 1ps
`default_nettype none

module q_table_update_and_greedy_select
    import qtu_pkg::*;
#(
    parameter int STATE_COUNT = STATE_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ROW_AW = $clog2(STATE_COUNT);
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(STATE_COUNT - 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MAX   = 9'b000000100,
        S_MUL1  = 9'b000001000,
        S_MUL2  = 9'b000010000,
        S_MUL3  = 9'b000100000,
        S_WR    = 9'b001000000,
        S_SEL   = 9'b010000000,
        S_REJ   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [ROW_AW-1:0] clr_cnt_reg;
    logic [15:0]       lr_reg;
    logic [15:0]       disc_reg;
    logic [16:0]       siu_reg;

    logic [STATE_W-1:0] cur_reg;
    logic [ACT_W-1:0]   act_reg;
    qval_t              reward_reg;
    logic [ACTIONS-1:0] mask_reg;

    qrow_t mem [STATE_COUNT];
    qrow_t rd_row_reg;
    qrow_t wr_row;
    logic              mem_re;
    logic              mem_we;
    logic [ROW_AW-1:0] mem_raddr;
    logic [ROW_AW-1:0] mem_waddr;
    qrow_t             mem_wdata;

    qval_t              m_reg;
    logic signed [47:0] p1_reg;
    logic signed [47:0] p1_next;
    logic signed [47:0] p1_rnd;
    logic signed [32:0] t_reg;
    logic signed [32:0] t_next;
    logic signed [48:0] pold_reg;
    logic signed [48:0] pold_next;
    logic signed [49:0] pt_reg;
    logic signed [49:0] pt_next;
    logic signed [50:0] acc_sum;
    logic signed [34:0] acc_rnd;
    qval_t              acc_sat;
    logic [16:0]        inv_lr;

    logic [ACTIONS-1:0] best_mask;
    logic [ACT_W-1:0]   best_idx;
    qval_t              best_val;
    qval_t              old_val;

    logic accept;
    logic cur_ok;
    logic nxt_ok;
    logic req_ok;
    logic rsp_free;
    logic rsp_load;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cur_ok = ({1'b0, req.current_state} < siu_reg)
                 && (32'(req.current_state) < 32'(STATE_COUNT));
    assign nxt_ok = ({1'b0, req.next_state} < siu_reg)
                 && (32'(req.next_state) < 32'(STATE_COUNT));
    assign req_ok = cur_ok && ((req.cmd == CMD_SELECT) || nxt_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= LEARNING_RATE_RST;
            disc_reg <= DISCOUNT_RST;
            siu_reg  <= STATES_IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE: lr_reg   <= cfg_data[15:0];
                CFG_DISCOUNT:      disc_reg <= cfg_data[15:0];
                CFG_STATES_IN_USE: siu_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // table port
    assign mem_re    = (accept && req_ok) || (state_reg == S_MAX);
    assign mem_raddr = (state_reg == S_MAX) ? ROW_AW'(cur_reg)
                     : (req.cmd == CMD_SELECT) ? ROW_AW'(req.current_state)
                     : ROW_AW'(req.next_state);
    assign mem_we    = (state_reg == S_CLEAR) || ((state_reg == S_WR) && rsp_free);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : ROW_AW'(cur_reg);
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : wr_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_row_reg <= mem[mem_raddr];
        end
    end

    assign best_mask = (state_reg == S_SEL) ? mask_reg : '1;

    qtu_best u_best (
        .row   (rd_row_reg),
        .mask  (best_mask),
        .idx   (best_idx),
        .value (best_val)
    );

    assign old_val = rd_row_reg[act_reg];

    // update arithmetic
    assign p1_next   = $signed({1'b0, disc_reg}) * m_reg;
    assign p1_rnd    = p1_reg + 48'sd32768;
    assign t_next    = {p1_rnd[47], p1_rnd[47:16]} + {reward_reg[31], reward_reg};
    assign inv_lr    = 17'h10000 - {1'b0, lr_reg};
    assign pold_next = $signed({1'b0, inv_lr}) * old_val;
    assign pt_next   = $signed({1'b0, lr_reg}) * t_reg;
    assign acc_sum   = {{2{pold_reg[48]}}, pold_reg} + {pt_reg[49], pt_reg}
                     + 51'sd32768;
    assign acc_rnd   = acc_sum[50:16];

    always_comb
    begin
        if ((acc_rnd[34:31] == 4'b0000) || (acc_rnd[34:31] == 4'b1111))
        begin
            acc_sat = acc_rnd[31:0];
        end
        else if (acc_rnd[34])
        begin
            acc_sat = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(Q_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        wr_row          = rd_row_reg;
        wr_row[act_reg] = acc_sat;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg    <= req.current_state;
            act_reg    <= req.action;
            reward_reg <= req.reward;
            mask_reg   <= req.allowed_mask;
        end
        if (state_reg == S_MAX)
        begin
            m_reg <= best_val;
        end
        if (state_reg == S_MUL1)
        begin
            p1_reg <= p1_next;
        end
        if (state_reg == S_MUL2)
        begin
            t_reg    <= t_next;
            pold_reg <= pold_next;
        end
        if (state_reg == S_MUL3)
        begin
            pt_reg <= pt_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (!req_ok)
                    begin
                        state_next = S_REJ;
                    end
                    else if (req.cmd == CMD_SELECT)
                    begin
                        state_next = S_SEL;
                    end
                    else
                    begin
                        state_next = S_MAX;
                    end
                end
            end
            S_MAX:  state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_MUL3;
            S_MUL3: state_next = S_WR;
            S_WR, S_SEL, S_REJ:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_AW'(1);
            end
        end
    end

    // result
    assign rsp_load = rsp_free
                   && ((state_reg == S_WR) || (state_reg == S_SEL) || (state_reg == S_REJ));

    always_comb
    begin
        rsp_next.chosen_action = act_reg;
        rsp_next.q_value       = '0;
        rsp_next.valid_res     = 1'b0;
        if (state_reg == S_WR)
        begin
            rsp_next.q_value   = acc_sat;
            rsp_next.valid_res = 1'b1;
        end
        else if (state_reg == S_SEL)
        begin
            rsp_next.valid_res = 1'b1;
            if (mask_reg == '0)
            begin
                rsp_next.q_value = old_val;
            end
            else
            begin
                rsp_next.chosen_action = best_idx;
                rsp_next.q_value       = best_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table read and write in the same cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) && rsp_free |=> rsp_valid && rsp.valid_res)
        else $error("write-back without a valid result");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.valid_res |-> (rsp.q_value == '0))
        else $error("rejected request carries a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req_ready && !rsp_valid)
        else $error("request traffic during clearing pass");

endmodule

`default_nettype wire

>>> tb/tb_q_table_update_and_greedy_select.sv
// Self-checking testbench for the Q-table update and greedy select block.
`timescale 1ns / 1ps

module tb_q_table_update_and_greedy_select;
    import qtu_pkg::*;

    localparam int STATE_COUNT = STATE_COUNT_DEF;
    localparam int STUCK_LIMIT = 4 * STATE_COUNT + 10000;
    localparam int PHASE_ITEMS = 100;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    class q_table_tracker;
        int     alpha;
        int     gamma;
        int     state_limit;
        int     state_count;
        int     q_mem[int];
        rsp_t   pending[$];
        int     fails;

        function new(int count);
            state_count = count;
            alpha       = int'(LEARNING_RATE_RST);
            gamma       = int'(DISCOUNT_RST);
            state_limit = int'(STATES_IN_USE_RST);
            fails       = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LEARNING_RATE: alpha = int'(data[15:0]);
                CFG_DISCOUNT:      gamma = int'(data[15:0]);
                CFG_STATES_IN_USE: state_limit = int'(data);
                default: ;
            endcase
        endfunction

        function longint entry(int k);
            return q_mem.exists(k) ? longint'(q_mem[k]) : 64'sd0;
        endfunction

        function bit state_ok(int s);
            return s < state_limit && s < state_count;
        endfunction

        function longint round16(longint x);
            return (x + 64'sd32768) >>> 16;
        endfunction

        function void note_request(req_t r);
            rsp_t   res;
            int     cur;
            int     nxt;
            int     dst;
            longint best;
            longint old;
            longint target;
            longint acc;
            longint v;
            bit     have;
            cur = int'(r.current_state);
            nxt = int'(r.next_state);
            res.chosen_action = r.action;
            res.q_value       = '0;
            res.valid_res     = 1'b0;
            if (r.cmd == CMD_UPDATE) begin
                if (state_ok(cur) && state_ok(nxt)) begin
                    best = entry(nxt * ACTIONS);
                    for (int i = 1; i < ACTIONS; i++) begin
                        v = entry(nxt * ACTIONS + i);
                        if (v > best)
                            best = v;
                    end
                    dst    = cur * ACTIONS + int'(r.action);
                    old    = entry(dst);
                    target = longint'($signed(r.reward)) + round16(longint'(gamma) * best);
                    acc    = round16(longint'(65536 - alpha) * old + longint'(alpha) * target);
                    if (acc > Q_MAX)
                        acc = Q_MAX;
                    if (acc < Q_MIN)
                        acc = Q_MIN;
                    q_mem[dst]    = int'(acc);
                    res.q_value   = acc[31:0];
                    res.valid_res = 1'b1;
                end
            end
            else if (state_ok(cur)) begin
                res.valid_res = 1'b1;
                if (r.allowed_mask == '0) begin
                    v           = entry(cur * ACTIONS + int'(r.action));
                    res.q_value = v[31:0];
                end
                else begin
                    have = 1'b0;
                    best = 0;
                    for (int i = 0; i < ACTIONS; i++) begin
                        v = entry(cur * ACTIONS + i);
                        if (r.allowed_mask[i] && (!have || v > best)) begin
                            best              = v;
                            res.chosen_action = ACT_W'(i);
                            have              = 1'b1;
                        end
                    end
                    res.q_value = best[31:0];
                end
            end
            pending.insert(pending.size(), res);
        endfunction

        function void mismatch(string field, longint want, longint got);
            fails++;
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending.size() == 0) begin
                fails++;
                $error("result arrived with no request pending");
                return;
            end
            want = pending.pop_front();
            if (got.chosen_action !== want.chosen_action)
                mismatch("chosen_action", want.chosen_action, got.chosen_action);
            if (got.q_value !== want.q_value)
                mismatch("q_value", longint'($signed(want.q_value)),
                         longint'($signed(got.q_value)));
            if (got.valid_res !== want.valid_res)
                mismatch("valid_res", want.valid_res, got.valid_res);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LEARNING_RATE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    q_table_tracker tracker = new(STATE_COUNT);
    int             stuck_cycles = 0;
    int             rsp_count = 0;
    int             quiet_left = 0;

    q_table_update_and_greedy_select #(
        .STATE_COUNT (STATE_COUNT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (req_valid && req_ready)
            tracker.note_request(req);
        if (rsp_valid && rsp_ready) begin
            tracker.check_result(rsp);
            rsp_count <= rsp_count + 1;
        end
        if (cfg_valid && cfg_ready)
            tracker.write_register(cfg_index, cfg_data);
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // receiver: random stalls, steady stretches, one long hold-off
    initial
    begin
        int  hold_left;
        int  mode_left;
        bit  steady;
        bit  long_hold_done;
        hold_left      = 0;
        mode_left      = 0;
        steady         = 1'b1;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!long_hold_done && rsp_count >= 400) begin
                hold_left      = 300;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else begin
                rsp_ready <= 1'b1;
                if (mode_left == 0) begin
                    steady    = ($urandom_range(0, 2) == 0);
                    mode_left = $urandom_range(20, 120);
                end
                else
                    mode_left--;
                if (!steady && $urandom_range(0, 3) == 0)
                    hold_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                           : $urandom_range(10, 40);
            end
        end
    end

    function automatic req_t make_req(logic cmd, int cur, int act, int nxt, int reward,
                                      int mask);
        req_t r;
        r.cmd           = cmd;
        r.current_state = STATE_W'(cur);
        r.action        = ACT_W'(act);
        r.next_state    = STATE_W'(nxt);
        r.reward        = Q_W'(reward);
        r.allowed_mask  = ACTIONS'(mask);
        return r;
    endfunction

    function automatic int next_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_state(int limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 15);
        if (r < 82 && limit > 0)
            return (limit - 1 + $urandom_range(0, 1)) & 16'hFFFF;
        if (r < 90)
            return 65535 - $urandom_range(0, 1);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int pick_reward();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        if (r < 55)
            return 32'h7FFFFFFF;
        if (r < 70)
            return 32'h80000000;
        return $urandom;
    endfunction

    function automatic int pick_fraction();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 0;
        if (r < 4)
            return 65535;
        return $urandom_range(0, 65535);
    endfunction

    task automatic send_request(req_t r);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_register(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_config(int lr, int disc, int limit);
        push_register(CFG_LEARNING_RATE, lr);
        push_register(CFG_DISCOUNT, disc);
        push_register(CFG_STATES_IN_USE, limit);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // reset register values
        send_request(make_req(CMD_SELECT, 0, 3, 0, 0, 4'b0000));
        send_request(make_req(CMD_UPDATE, 0, 1, 0, 32'h7FFFFFFF, 4'b0000));
        send_request(make_req(CMD_UPDATE, 0, 2, 0, 32'h80000000, 4'b1111));
        send_request(make_req(CMD_SELECT, 0, 0, 0, 0, 4'b1111));
        send_request(make_req(CMD_SELECT, 0, 0, 9, 32'h12345678, 4'b0110));
        send_request(make_req(CMD_SELECT, 0, 2, 0, 0, 4'b0000));
        send_request(make_req(CMD_SELECT, 0, 1, 0, 0, 4'b1001));
        send_request(make_req(CMD_UPDATE, 51200, 0, 0, 1000, 4'b0000));
        send_request(make_req(CMD_UPDATE, 51199, 3, 51200, 1000, 4'b0000));
        send_request(make_req(CMD_UPDATE, 51199, 3, 0, 32'h00010000, 4'b0000));
        send_request(make_req(CMD_SELECT, 51200, 2, 0, 0, 4'b1111));
        send_request(make_req(CMD_SELECT, 65535, 1, 0, 0, 4'b1111));
        wait_drained();
        // full-scale fractions, every state usable: drive into saturation
        program_config(65535, 65535, 65536);
        repeat (3) send_request(make_req(CMD_UPDATE, 65535, 3, 65535, 32'h7FFFFFFF, 0));
        send_request(make_req(CMD_SELECT, 65535, 0, 0, 0, 4'b1111));
        repeat (3) send_request(make_req(CMD_UPDATE, 1, 0, 1, 32'h80000000, 0));
        send_request(make_req(CMD_SELECT, 1, 2, 0, 0, 4'b0001));
        wait_drained();
        // zero fractions, single usable state
        program_config(0, 0, 1);
        send_request(make_req(CMD_UPDATE, 0, 1, 0, 5, 0));
        send_request(make_req(CMD_UPDATE, 1, 1, 0, 5, 0));
        send_request(make_req(CMD_SELECT, 0, 3, 0, 0, 4'b1111));
        wait_drained();
        // no usable state at all
        program_config(6554, 62259, 0);
        send_request(make_req(CMD_SELECT, 0, 2, 0, 0, 4'b1111));
        send_request(make_req(CMD_UPDATE, 0, 0, 0, 77, 0));
        wait_drained();
    endtask

    task automatic run_random();
        int limits[7];
        int lr;
        int disc;
        limits = '{16, 65536, 4, 0, 1, 8, 0};
        limits[3] = $urandom_range(1, 65536);
        limits[6] = $urandom_range(1, 65536);
        for (int p = 0; p < 7; p++) begin
            lr   = (p == 1) ? 65535 : (p == 2) ? 0 : pick_fraction();
            disc = (p == 1) ? 0 : (p == 2) ? 65535 : pick_fraction();
            program_config(lr, disc, limits[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_request(make_req(1'($urandom_range(0, 1)), pick_state(limits[p]),
                                      $urandom_range(0, 3), pick_state(limits[p]),
                                      pick_reward(), $urandom_range(0, 15)));
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        wait_drained();
        repeat (20) @(posedge clk);
        if (tracker.fails == 0 && tracker.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
